@@ rtl/c8_pkg.sv @@
// shared types, codes and defaults of the chip-8 instruction core
package c8_pkg;

  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;
  localparam int MEMORY_BYTES_DEF  = 4096;
  localparam int STACK_DEPTH_DEF   = 16;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_FRAME   = 3'd2;
  localparam logic [2:0] ST_KEY     = 3'd3;
  localparam logic [2:0] ST_SOUND   = 3'd4;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_EXEC  = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_KEY   = 3'd3;
  localparam logic [2:0] OP_PIXEL = 3'd4;

  localparam logic [2:0] REG_SHIFT  = 3'd0;
  localparam logic [2:0] REG_WRAP   = 3'd1;
  localparam logic [2:0] REG_KEEP   = 3'd2;
  localparam logic [2:0] REG_VBLANK = 3'd3;
  localparam logic [2:0] REG_FONT   = 3'd4;
  localparam logic [2:0] REG_BOOT   = 3'd5;

  localparam logic [11:0] BOOT_RESET = 12'h200;

  localparam logic [15:0] W_CLEAR  = 16'h00E0;
  localparam logic [15:0] W_RETURN = 16'h00EE;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [15:0] keys_held;
    logic [7:0]  random_byte;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] program_counter;
    logic [15:0] bad_instruction;
    logic [7:0]  sound_duration;
    logic        pixel_value;
  } result_t;

  typedef struct packed {
    logic        shift_in_place;
    logic        wrap_sprites;
    logic        keep_index;
    logic        await_vblank;
    logic [11:0] font_base;
    logic [11:0] boot_address;
  } cfg_t;

  typedef enum logic [2:0] {
    CL_LOAD, CL_EXEC, CL_TICK, CL_KEY, CL_PIXEL, CL_NONE
  } class_t;

  typedef struct packed {
    request_t req;
    class_t   cls;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH_HI, S_FETCH_LO, S_REGRD, S_EXEC, S_FLAG, S_MODX, S_MODY,
    S_DRAW_RD, S_DRAW_WR, S_BCD, S_BLK_RD, S_BLK_WR, S_PIX_DIV, S_PIX_RD, S_DONE
  } state_t;

endpackage

@@ rtl/c8_front.sv @@
// input queue that classifies each item on entry
module c8_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  c8_pkg::request_t  request,
  input  logic              pop,
  output logic              empty,
  output c8_pkg::entry_t    head
);

  c8_pkg::entry_t slot [2];
  c8_pkg::class_t cls;
  logic           wp, rp;
  logic [1:0]     cnt;
  logic           do_push, do_pop;

  always_comb begin
    case (request.opcode)
      c8_pkg::OP_LOAD:  cls = c8_pkg::CL_LOAD;
      c8_pkg::OP_EXEC:  cls = c8_pkg::CL_EXEC;
      c8_pkg::OP_TICK:  cls = c8_pkg::CL_TICK;
      c8_pkg::OP_KEY:   cls = c8_pkg::CL_KEY;
      c8_pkg::OP_PIXEL: cls = c8_pkg::CL_PIXEL;
      default:          cls = c8_pkg::CL_NONE;
    endcase
  end

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign head    = slot[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wp] <= '{req: request, cls: cls};
  end

endmodule

@@ rtl/c8_rq.sv @@
// two-entry result queue
module c8_rq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  c8_pkg::result_t  data,
  input  logic             pop,
  output logic             empty,
  output c8_pkg::result_t  head
);

  c8_pkg::result_t slot [2];
  logic            wp, rp;
  logic [1:0]      cnt;
  logic            do_push, do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign head    = slot[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wp] <= data;
  end

endmodule

@@ rtl/c8_exec.sv @@
// sequencer that carries out items: memories, registers, draw and transfer loops
module c8_exec #(
  parameter int SCREEN_WIDTH  = c8_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = c8_pkg::SCREEN_HEIGHT_DEF,
  parameter int MEMORY_BYTES  = c8_pkg::MEMORY_BYTES_DEF,
  parameter int STACK_DEPTH   = c8_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  c8_pkg::cfg_t     cfg,
  input  c8_pkg::entry_t   head,
  input  logic             q_empty,
  output logic             q_pop,
  output c8_pkg::result_t  res,
  output logic             res_push,
  input  logic             res_full
);

  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam logic [13:0]   PIX_COUNT = 14'(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam logic [8:0]    W9  = 9'(SCREEN_WIDTH);
  localparam logic [7:0]    W8  = 8'(SCREEN_WIDTH);
  localparam logic [11:0]   W12 = 12'(SCREEN_WIDTH);
  localparam logic [7:0]    H8  = 8'(SCREEN_HEIGHT);
  localparam logic [YW:0]   HR  = (YW + 1)'(SCREEN_HEIGHT);
  localparam logic [SW-1:0] SP_LAST = SW'(STACK_DEPTH - 1);

  c8_pkg::state_t   state, state_next;
  c8_pkg::request_t cur;

  logic [7:0]  hi, lo;
  logic [11:0] pc;
  logic [15:0] idx;
  logic [SW-1:0] sp, sp_dec, sp_inc;
  logic [11:0] stack [STACK_DEPTH];
  logic [7:0]  delay;
  logic [3:0]  key_target;
  logic [2:0]  status_r;
  logic [15:0] bad_r;
  logic [7:0]  dur_r;
  logic        pix_r;
  logic        flag;
  logic        coll;
  logic [4:0]  k, r;
  logic [YW:0] rowc;
  logic [7:0]  px, py;
  logic [11:0] rem;

  // program memory
  logic [7:0]    mem [MEMORY_BYTES];
  logic [7:0]    mem_q;
  logic          m_we, m_re;
  logic [AW-1:0] m_wa, m_ra;
  logic [7:0]    m_wd;

  // data registers
  logic [7:0]  rf [16];
  logic [15:0] rf_valid;
  logic [7:0]  va, vb;
  logic        rf_we, rf_rea, rf_reb;
  logic [3:0]  rf_wa, rf_raa, rf_rab;
  logic [7:0]  rf_wd;

  // frame buffer rows
  logic [SCREEN_WIDTH-1:0]  fb [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] fb_valid;
  logic [SCREEN_WIDTH-1:0]  fb_q, fb_row, fb_wd, mask;
  logic                     fb_qv, fb_re, fb_we, fb_clr;
  logic [YW-1:0]            fb_ra, fb_wa;

  logic [15:0] word, pc16, pc1_16, load16, idx_k;
  logic [11:0] nnn;
  logic [3:0]  x, y, n, grp;
  logic        illegal;
  logic [7:0]  src, alu_val;
  logic        alu_flag, alu_ok, alu_flagged;
  logic [8:0]  sum9;
  logic [7:0]  rem100, digit;
  logic [1:0]  hund;
  logic [14:0] t15;
  logic [3:0]  tens;
  logic [7:0]  ones;
  logic        wide, draw_last, hit;
  logic [4:0]  rows;
  logic [8:0]  x0, xb, xr;

  assign word   = {hi, lo};
  assign nnn    = {hi[3:0], lo};
  assign x      = hi[3:0];
  assign grp    = hi[7:4];
  assign y      = lo[7:4];
  assign n      = lo[3:0];
  assign pc16   = {4'b0, pc};
  assign pc1_16 = {4'b0, pc + 12'd1};
  assign load16 = {4'b0, head.req.address};
  assign idx_k  = idx + {11'b0, k};
  assign sp_dec = (sp == '0) ? SP_LAST : sp - 1'b1;
  assign sp_inc = (sp == SP_LAST) ? '0 : sp + 1'b1;
  assign res    = '{status: status_r, program_counter: pc, bad_instruction: bad_r,
                    sound_duration: dur_r, pixel_value: pix_r};

  // arithmetic group
  assign src  = cfg.shift_in_place ? va : vb;
  assign sum9 = {1'b0, va} + {1'b0, vb};
  always_comb begin
    alu_ok      = 1'b1;
    alu_flagged = 1'b1;
    alu_val     = vb;
    alu_flag    = 1'b0;
    case (n)
      4'h0: alu_flagged = 1'b0;
      4'h1: alu_val = va | vb;
      4'h2: alu_val = va & vb;
      4'h3: alu_val = va ^ vb;
      4'h4: begin alu_val = sum9[7:0]; alu_flag = sum9[8]; end
      4'h5: begin alu_val = va - vb; alu_flag = (va >= vb); end
      4'h7: begin alu_val = vb - va; alu_flag = (vb >= va); end
      4'h6: begin alu_val = {1'b0, src[7:1]}; alu_flag = src[0]; end
      4'hE: begin alu_val = {src[6:0], 1'b0}; alu_flag = src[7]; end
      default: begin alu_ok = 1'b0; alu_flagged = 1'b0; end
    endcase
  end

  always_comb begin
    case (grp)
      4'h0:    illegal = (word != c8_pkg::W_CLEAR) && (word != c8_pkg::W_RETURN);
      4'h5:    illegal = (n != 4'h0);
      4'h9:    illegal = (n != 4'h0);
      4'h8:    illegal = !alu_ok;
      4'hE:    illegal = (lo != 8'h9E) && (lo != 8'hA1);
      4'hF:    illegal = !(lo inside {8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29,
                                      8'h33, 8'h55, 8'h65});
      default: illegal = 1'b0;
    endcase
  end

  // decimal digits: tens by reciprocal multiply, valid for remainders below 128
  assign hund   = (va >= 8'd200) ? 2'd2 : (va >= 8'd100) ? 2'd1 : 2'd0;
  assign rem100 = va - ((va >= 8'd200) ? 8'd200 : (va >= 8'd100) ? 8'd100 : 8'd0);
  assign t15    = {8'b0, rem100[6:0]} * 15'd205;
  assign tens   = t15[14:11];
  assign ones   = rem100 - {tens, 3'b0} - {3'b0, tens, 1'b0};
  assign digit  = (k == 5'd0) ? {6'b0, hund} : (k == 5'd1) ? {4'b0, tens} : ones;

  // sprite byte to row mask
  assign wide   = (n == 4'h0);
  assign rows   = wide ? 5'd16 : {1'b0, n};
  assign x0     = {1'b0, px} + ((wide && k[0]) ? 9'd8 : 9'd0);
  assign fb_row = fb_qv ? fb_q : '0;
  always_comb begin
    mask = '0;
    xb   = '0;
    xr   = '0;
    for (int b = 0; b < 8; b++) begin
      xb = x0 + 9'(b);
      xr = xb;
      if (xr >= W9) xr = xr - W9;
      if (xr >= W9) xr = xr - W9;
      if (mem_q[7-b] && (xb < W9 || cfg.wrap_sprites)) mask[xr[XW-1:0]] = 1'b1;
    end
  end
  assign hit   = |(fb_row & mask);
  assign fb_wd = fb_row ^ mask;
  assign draw_last = (wide && !k[0]) ? 1'b0 :
                     ((r + 5'd1) == rows) || ((rowc + 1'b1) == HR && !cfg.wrap_sprites);

  always_ff @(posedge clk) begin
    if (rst) state <= c8_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0; res_push = 1'b0;
    m_we = 1'b0; m_wa = '0; m_wd = '0; m_re = 1'b0; m_ra = '0;
    rf_we = 1'b0; rf_wa = '0; rf_wd = '0;
    rf_rea = 1'b0; rf_raa = '0; rf_reb = 1'b0; rf_rab = '0;
    fb_re = 1'b0; fb_ra = '0; fb_we = 1'b0; fb_wa = '0; fb_clr = 1'b0;
    case (state)
      c8_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          state_next = c8_pkg::S_DONE;
          case (head.cls)
            c8_pkg::CL_LOAD: begin
              m_we = 1'b1; m_wa = load16[AW-1:0]; m_wd = head.req.data_byte;
            end
            c8_pkg::CL_EXEC: state_next = c8_pkg::S_FETCH_HI;
            c8_pkg::CL_KEY: begin
              rf_we = 1'b1; rf_wa = key_target; rf_wd = {4'b0, head.req.data_byte[3:0]};
            end
            c8_pkg::CL_PIXEL:
              if ({2'b0, head.req.address} < PIX_COUNT) state_next = c8_pkg::S_PIX_DIV;
            default: state_next = c8_pkg::S_DONE;
          endcase
        end
      end
      c8_pkg::S_FETCH_HI: begin
        m_re = 1'b1; m_ra = pc16[AW-1:0]; state_next = c8_pkg::S_FETCH_LO;
      end
      c8_pkg::S_FETCH_LO: begin
        m_re = 1'b1; m_ra = pc1_16[AW-1:0]; state_next = c8_pkg::S_REGRD;
      end
      c8_pkg::S_REGRD: begin
        rf_rea = 1'b1; rf_raa = hi[3:0];
        rf_reb = 1'b1; rf_rab = (hi[7:4] == 4'hB) ? 4'h0 : mem_q[7:4];
        state_next = c8_pkg::S_EXEC;
      end
      c8_pkg::S_EXEC: begin
        state_next = c8_pkg::S_DONE;
        case (grp)
          4'h0: fb_clr = (word == c8_pkg::W_CLEAR);
          4'h6: begin rf_we = 1'b1; rf_wa = x; rf_wd = lo; end
          4'h7: begin rf_we = 1'b1; rf_wa = x; rf_wd = va + lo; end
          4'hC: begin rf_we = 1'b1; rf_wa = x; rf_wd = cur.random_byte & lo; end
          4'h8: begin
            if (alu_ok) begin
              rf_we = 1'b1; rf_wa = x; rf_wd = alu_val;
              if (alu_flagged) state_next = c8_pkg::S_FLAG;
            end
          end
          4'hD: state_next = c8_pkg::S_MODX;
          4'hF: begin
            case (lo)
              8'h07: begin rf_we = 1'b1; rf_wa = x; rf_wd = delay; end
              8'h33: state_next = c8_pkg::S_BCD;
              8'h55, 8'h65: state_next = c8_pkg::S_BLK_RD;
              default: state_next = c8_pkg::S_DONE;
            endcase
          end
          default: state_next = c8_pkg::S_DONE;
        endcase
      end
      c8_pkg::S_FLAG: begin
        rf_we = 1'b1; rf_wa = 4'hF; rf_wd = {7'b0, flag}; state_next = c8_pkg::S_DONE;
      end
      c8_pkg::S_MODX: if (px < W8) state_next = c8_pkg::S_MODY;
      c8_pkg::S_MODY: if (py < H8) state_next = c8_pkg::S_DRAW_RD;
      c8_pkg::S_DRAW_RD: begin
        m_re = 1'b1; m_ra = idx_k[AW-1:0];
        fb_re = 1'b1; fb_ra = rowc[YW-1:0];
        state_next = c8_pkg::S_DRAW_WR;
      end
      c8_pkg::S_DRAW_WR: begin
        fb_we = 1'b1; fb_wa = rowc[YW-1:0];
        state_next = draw_last ? c8_pkg::S_FLAG : c8_pkg::S_DRAW_RD;
      end
      c8_pkg::S_BCD: begin
        m_we = 1'b1; m_wa = idx_k[AW-1:0]; m_wd = digit;
        if (k == 5'd2) state_next = c8_pkg::S_DONE;
      end
      c8_pkg::S_BLK_RD: begin
        if (lo == 8'h55) begin rf_rea = 1'b1; rf_raa = k[3:0]; end
        else begin m_re = 1'b1; m_ra = idx_k[AW-1:0]; end
        state_next = c8_pkg::S_BLK_WR;
      end
      c8_pkg::S_BLK_WR: begin
        if (lo == 8'h55) begin m_we = 1'b1; m_wa = idx_k[AW-1:0]; m_wd = va; end
        else begin rf_we = 1'b1; rf_wa = k[3:0]; rf_wd = mem_q; end
        state_next = (k[3:0] == x) ? c8_pkg::S_DONE : c8_pkg::S_BLK_RD;
      end
      c8_pkg::S_PIX_DIV: begin
        if (rem < W12) begin
          fb_re = 1'b1; fb_ra = rowc[YW-1:0]; state_next = c8_pkg::S_PIX_RD;
        end
      end
      c8_pkg::S_PIX_RD: state_next = c8_pkg::S_DONE;
      c8_pkg::S_DONE: begin
        if (!res_full) begin res_push = 1'b1; state_next = c8_pkg::S_IDLE; end
      end
      default: state_next = c8_pkg::S_IDLE;
    endcase
  end

  // architectural state and per-item work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= c8_pkg::BOOT_RESET;
      idx <= '0;
      sp <= '0;
      delay <= '0;
      key_target <= '0;
    end else begin
      case (state)
        c8_pkg::S_IDLE: begin
          if (!q_empty && head.cls == c8_pkg::CL_TICK && delay != 8'd0)
            delay <= delay - 8'd1;
        end
        c8_pkg::S_REGRD: pc <= pc + 12'd2;
        c8_pkg::S_EXEC: begin
          case (grp)
            4'h0: if (word == c8_pkg::W_RETURN) begin sp <= sp_dec; pc <= stack[sp_dec]; end
            4'h1: pc <= nnn;
            4'h2: begin sp <= sp_inc; pc <= nnn; end
            4'h3: if (va == lo) pc <= pc + 12'd2;
            4'h4: if (va != lo) pc <= pc + 12'd2;
            4'h5: if (n == 4'h0 && va == vb) pc <= pc + 12'd2;
            4'h9: if (n == 4'h0 && va != vb) pc <= pc + 12'd2;
            4'hA: idx <= {4'b0, nnn};
            4'hB: pc <= nnn + {4'b0, vb};
            4'hE: begin
              if (lo == 8'h9E && cur.keys_held[va[3:0]]) pc <= pc + 12'd2;
              if (lo == 8'hA1 && !cur.keys_held[va[3:0]]) pc <= pc + 12'd2;
            end
            4'hF: begin
              case (lo)
                8'h0A: key_target <= x;
                8'h15: delay <= va;
                8'h1E: idx <= idx + {8'b0, va};
                8'h29: idx <= {4'b0, cfg.font_base} + {10'b0, va[3:0], 2'b0}
                              + {12'b0, va[3:0]};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        c8_pkg::S_BLK_WR: begin
          if (k[3:0] == x && !cfg.keep_index) idx <= idx + {12'b0, x} + 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == c8_pkg::S_EXEC && grp == 4'h2) stack[sp] <= pc;
  end

  always_ff @(posedge clk) begin
    case (state)
      c8_pkg::S_IDLE: begin
        cur <= head.req;
        status_r <= c8_pkg::ST_OK;
        bad_r <= '0;
        dur_r <= '0;
        pix_r <= 1'b0;
        rem <= head.req.address;
        rowc <= '0;
        k <= '0;
      end
      c8_pkg::S_FETCH_LO: hi <= mem_q;
      c8_pkg::S_REGRD: lo <= mem_q;
      c8_pkg::S_EXEC: begin
        k <= '0;
        flag <= alu_flag;
        coll <= 1'b0;
        px <= va;
        py <= vb;
        if (illegal) begin
          status_r <= c8_pkg::ST_ILLEGAL;
          bad_r <= word;
        end else if ((grp == 4'h0 && word == c8_pkg::W_CLEAR) || grp == 4'hD) begin
          status_r <= cfg.await_vblank ? c8_pkg::ST_FRAME : c8_pkg::ST_OK;
        end else if (grp == 4'hF && lo == 8'h0A) begin
          status_r <= c8_pkg::ST_KEY;
        end else if (grp == 4'hF && lo == 8'h18) begin
          status_r <= c8_pkg::ST_SOUND;
          dur_r <= (va == 8'd1) ? 8'd2 : va;
        end
      end
      c8_pkg::S_MODX: if (px >= W8) px <= px - W8;
      c8_pkg::S_MODY: begin
        if (py >= H8) py <= py - H8;
        else begin
          rowc <= {1'b0, py[YW-1:0]};
          r <= '0;
        end
      end
      c8_pkg::S_DRAW_WR: begin
        coll <= coll | hit;
        k <= k + 5'd1;
        if (draw_last) flag <= coll | hit;
        else if (!wide || k[0]) begin
          r <= r + 5'd1;
          rowc <= ((rowc + 1'b1) == HR) ? '0 : rowc + 1'b1;
        end
      end
      c8_pkg::S_BCD: k <= k + 5'd1;
      c8_pkg::S_BLK_WR: k <= k + 5'd1;
      c8_pkg::S_PIX_DIV: begin
        if (rem >= W12) begin
          rem <= rem - W12;
          rowc <= rowc + 1'b1;
        end
      end
      c8_pkg::S_PIX_RD: pix_r <= fb_qv & fb_q[rem[XW-1:0]];
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (m_we) mem[m_wa] <= m_wd;
    if (m_re) mem_q <= mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (rf_rea) va <= rf_valid[rf_raa] ? rf[rf_raa] : 8'd0;
    if (rf_reb) vb <= rf_valid[rf_rab] ? rf[rf_rab] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) rf_valid <= '0;
    else if (rf_we) rf_valid[rf_wa] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb[fb_wa] <= fb_wd;
    if (fb_re) begin
      fb_q  <= fb[fb_ra];
      fb_qv <= fb_valid[fb_ra];
    end
  end

  // a row that is not valid reads as cleared
  always_ff @(posedge clk) begin
    if (rst || fb_clr) fb_valid <= '0;
    else if (fb_we) fb_valid[fb_wa] <= 1'b1;
  end

endmodule

@@ rtl/chip8_instruction_core.sv @@
// top level of the chip-8 instruction core: queues, sequencer and register port
//
// Items enter on request with push/full and results leave on result with
// empty/pop; every item gives exactly one result, in order. Items wait in a
// two-entry queue where they are classified; a sequencer carries them out and
// puts results into a two-entry result queue, so either side can stall alone.
// A full result queue holds the sequencer, and the input queue then fills.
// One item at a time is carried out. A draw takes the column and row
// reductions (one subtract a cycle) plus a read per sprite byte on the single
// program memory port. A pixel read walks the row by repeated subtraction.
// Reset (synchronous) clears registers, stack pointer, timer and the frame
// buffer at once through row valid bits, sets pc to 0x200 and restores the
// register defaults; program memory keeps whatever it held.
// Write registers through the apb-style port only while the core is idle;
// the block itself does not enforce it.
module chip8_instruction_core #(
  parameter int SCREEN_WIDTH  = c8_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = c8_pkg::SCREEN_HEIGHT_DEF,
  parameter int MEMORY_BYTES  = c8_pkg::MEMORY_BYTES_DEF,
  parameter int STACK_DEPTH   = c8_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  c8_pkg::request_t request,
  output logic             empty,
  input  logic             pop,
  output c8_pkg::result_t  result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  c8_pkg::cfg_t    cfg;
  c8_pkg::entry_t  head;
  c8_pkg::result_t res;
  logic            q_empty, q_pop, res_push, res_full;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{shift_in_place: 1'b0, wrap_sprites: 1'b0, keep_index: 1'b0,
               await_vblank: 1'b1, font_base: 12'd0, boot_address: c8_pkg::BOOT_RESET};
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        c8_pkg::REG_SHIFT:  cfg.shift_in_place <= pwdata[0];
        c8_pkg::REG_WRAP:   cfg.wrap_sprites   <= pwdata[0];
        c8_pkg::REG_KEEP:   cfg.keep_index     <= pwdata[0];
        c8_pkg::REG_VBLANK: cfg.await_vblank   <= pwdata[0];
        c8_pkg::REG_FONT:   cfg.font_base      <= pwdata[11:0];
        c8_pkg::REG_BOOT:   cfg.boot_address   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      c8_pkg::REG_SHIFT:  prdata = {31'b0, cfg.shift_in_place};
      c8_pkg::REG_WRAP:   prdata = {31'b0, cfg.wrap_sprites};
      c8_pkg::REG_KEEP:   prdata = {31'b0, cfg.keep_index};
      c8_pkg::REG_VBLANK: prdata = {31'b0, cfg.await_vblank};
      c8_pkg::REG_FONT:   prdata = {20'b0, cfg.font_base};
      c8_pkg::REG_BOOT:   prdata = {20'b0, cfg.boot_address};
      default:            prdata = 32'd0;
    endcase
  end

  c8_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .pop(q_pop), .empty(q_empty), .head(head)
  );

  c8_exec #(
    .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .MEMORY_BYTES(MEMORY_BYTES), .STACK_DEPTH(STACK_DEPTH)
  ) u_exec (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .q_empty(q_empty), .q_pop(q_pop),
    .res(res), .res_push(res_push), .res_full(res_full)
  );

  c8_rq u_rq (
    .clk(clk), .rst(rst), .push(res_push), .full(res_full), .data(res),
    .pop(pop), .empty(empty), .head(result)
  );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the chip-8 instruction core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import c8_pkg::*;

  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  request_t request = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  chip8_instruction_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the core
  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [11:0] pc_q;
  logic [11:0] stack_q [16];
  bit          stack_set [16];
  logic [3:0]  sp_q;
  logic [7:0]  mem_q [4096];
  bit          mem_set [4096];
  bit          screen [2048];
  logic [7:0]  delay_q;
  logic [3:0]  key_reg;
  bit          q_shift, q_wrap, q_keep, q_vblank;
  logic [11:0] font_q, boot_q;

  result_t expected_q [$];
  int errors = 0;
  int hold_left = 0;
  bit quiet = 1'b0;

  task automatic mem_write(input logic [15:0] k, input logic [7:0] val);
    logic [15:0] a;
    begin
      a = ireg + k;
      mem_q[a[11:0]] = val;
      mem_set[a[11:0]] = 1'b1;
    end
  endtask

  task automatic plot_row(input int x0, input int y, input logic [7:0] bits);
    int x;
    begin
      for (int b = 0; b < 8; b++) begin
        x = x0 + b;
        if (bits[7-b]) begin
          if (x >= 64) begin
            if (!q_wrap) return;
            x = x % 64;
          end
          screen[y*64+x] ^= 1'b1;
          if (!screen[y*64+x]) vreg[15] = 8'd1;
        end
      end
    end
  endtask

  task automatic draw_sprite(input logic [3:0] x, input logic [3:0] y, input logic [3:0] n);
    int px, py, rows, row;
    logic [15:0] a;
    begin
      px = vreg[x] % 64;
      py = vreg[y] % 32;
      rows = (n == 0) ? 16 : n;
      vreg[15] = 8'd0;
      for (int r = 0; r < rows; r++) begin
        row = py + r;
        if (row >= 32) begin
          if (!q_wrap) break;
          row = row % 32;
        end
        if (n == 0) begin
          a = ireg + 16'(2*r);
          plot_row(px, row, mem_q[a[11:0]]);
          a = ireg + 16'(2*r+1);
          plot_row(px + 8, row, mem_q[a[11:0]]);
        end else begin
          a = ireg + 16'(r);
          plot_row(px, row, mem_q[a[11:0]]);
        end
      end
    end
  endtask

  task automatic run_instruction(input logic [7:0] hi, input logic [7:0] lo,
                                 input logic [15:0] keys, inout result_t e);
    logic [15:0] word;
    logic [11:0] nnn;
    logic [3:0] x, y, n, k;
    logic [8:0] sum;
    logic [7:0] f, a;
    bit bad;
    begin
      word = {hi, lo};
      nnn = word[11:0];
      x = hi[3:0];
      y = lo[7:4];
      n = lo[3:0];
      bad = 1'b0;
      pc_q = pc_q + 12'd2;
      case (hi[7:4])
        4'h0: begin
          if (word == W_CLEAR) begin
            for (int i = 0; i < 2048; i++) screen[i] = 1'b0;
            e.status = q_vblank ? ST_FRAME : ST_OK;
          end else if (word == W_RETURN) begin
            sp_q = sp_q - 4'd1;
            pc_q = stack_q[sp_q];
          end else bad = 1'b1;
        end
        4'h1: pc_q = nnn;
        4'h2: begin
          stack_q[sp_q] = pc_q;
          stack_set[sp_q] = 1'b1;
          sp_q = sp_q + 4'd1;
          pc_q = nnn;
        end
        4'h3: if (vreg[x] == lo) pc_q = pc_q + 12'd2;
        4'h4: if (vreg[x] != lo) pc_q = pc_q + 12'd2;
        4'h5: if (n != 0) bad = 1'b1; else if (vreg[x] == vreg[y]) pc_q = pc_q + 12'd2;
        4'h6: vreg[x] = lo;
        4'h7: vreg[x] = vreg[x] + lo;
        4'h8: begin
          case (n)
            4'h0: vreg[x] = vreg[y];
            4'h1: begin vreg[x] |= vreg[y]; vreg[15] = 8'd0; end
            4'h2: begin vreg[x] &= vreg[y]; vreg[15] = 8'd0; end
            4'h3: begin vreg[x] ^= vreg[y]; vreg[15] = 8'd0; end
            4'h4: begin
              sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
              vreg[x] = sum[7:0];
              vreg[15] = {7'd0, sum[8]};
            end
            4'h5: begin
              f = (vreg[x] >= vreg[y]) ? 8'd1 : 8'd0;
              vreg[x] = vreg[x] - vreg[y];
              vreg[15] = f;
            end
            4'h7: begin
              f = (vreg[y] >= vreg[x]) ? 8'd1 : 8'd0;
              vreg[x] = vreg[y] - vreg[x];
              vreg[15] = f;
            end
            4'h6: begin
              if (!q_shift) vreg[x] = vreg[y];
              f = {7'd0, vreg[x][0]};
              vreg[x] = vreg[x] >> 1;
              vreg[15] = f;
            end
            4'hE: begin
              if (!q_shift) vreg[x] = vreg[y];
              f = {7'd0, vreg[x][7]};
              vreg[x] = vreg[x] << 1;
              vreg[15] = f;
            end
            default: bad = 1'b1;
          endcase
        end
        4'h9: if (n != 0) bad = 1'b1; else if (vreg[x] != vreg[y]) pc_q = pc_q + 12'd2;
        4'hA: ireg = {4'd0, nnn};
        4'hB: pc_q = nnn + {4'd0, vreg[0]};
        4'hD: begin
          draw_sprite(x, y, n);
          e.status = q_vblank ? ST_FRAME : ST_OK;
        end
        4'hE: begin
          k = vreg[x][3:0];
          if (lo == 8'h9E) begin
            if (keys[k]) pc_q = pc_q + 12'd2;
          end else if (lo == 8'hA1) begin
            if (!keys[k]) pc_q = pc_q + 12'd2;
          end else bad = 1'b1;
        end
        default: begin
          case (lo)
            8'h07: vreg[x] = delay_q;
            8'h0A: begin key_reg = x; e.status = ST_KEY; end
            8'h15: delay_q = vreg[x];
            8'h18: begin
              e.status = ST_SOUND;
              e.sound_duration = (vreg[x] == 8'd1) ? 8'd2 : vreg[x];
            end
            8'h1E: ireg = ireg + {8'd0, vreg[x]};
            8'h29: ireg = {4'd0, font_q} + 16'(vreg[x][3:0]) * 16'd5;
            8'h33: begin
              a = vreg[x];
              mem_write(0, a / 8'd100);
              mem_write(1, (a / 8'd10) % 8'd10);
              mem_write(2, a % 8'd10);
            end
            8'h55, 8'h65: begin
              for (int i = 0; i <= x; i++) begin
                if (lo == 8'h55) mem_write(16'(i), vreg[i]);
                else begin
                  f = mem_q[12'(ireg + 16'(i))];
                  vreg[i] = f;
                end
              end
              if (!q_keep) ireg = ireg + {12'd0, x} + 16'd1;
            end
            default: bad = 1'b1;
          endcase
        end
      endcase
      if (bad) begin
        e.status = ST_ILLEGAL;
        e.bad_instruction = word;
      end
    end
  endtask

  task automatic predict_item(input request_t r);
    result_t e;
    logic [7:0] hi, lo;
    begin
      e = '0;
      case (r.opcode)
        OP_LOAD: begin
          mem_q[r.address] = r.data_byte;
          mem_set[r.address] = 1'b1;
        end
        OP_EXEC: begin
          hi = mem_q[pc_q];
          lo = mem_q[pc_q + 12'd1];
          if (hi[7:4] == 4'hC) begin
            pc_q = pc_q + 12'd2;
            vreg[hi[3:0]] = r.random_byte & lo;
          end else run_instruction(hi, lo, r.keys_held, e);
        end
        OP_TICK: if (delay_q != 0) delay_q = delay_q - 8'd1;
        OP_KEY: vreg[key_reg] = {4'd0, r.data_byte[3:0]};
        OP_PIXEL: if (r.address < 12'd2048) e.pixel_value = screen[r.address];
        default: ;
      endcase
      e.program_counter = pc_q;
      expected_q.push_back(e);
    end
  endtask

  function automatic request_t random_item(input logic [2:0] op);
    request_t r;
    r.opcode = op;
    r.address = 12'($urandom);
    r.data_byte = 8'($urandom);
    r.keys_held = 16'($urandom);
    r.random_byte = 8'($urandom);
    return r;
  endfunction

  task automatic send_item(input request_t r);
    begin
      request <= r;
      push <= 1'b1;
      @(posedge clk);
      while (full) @(posedge clk);
      predict_item(r);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  task automatic load_byte(input logic [11:0] a, input logic [7:0] val);
    request_t r;
    begin
      r = random_item(OP_LOAD);
      r.address = a;
      r.data_byte = val;
      send_item(r);
    end
  endtask

  // fill any bytes that the instruction will read but nobody has written
  task automatic fill_operands(input logic [15:0] w);
    int cnt;
    logic [11:0] a;
    begin
      cnt = 0;
      if (w[15:12] == 4'hD) cnt = (w[3:0] == 0) ? 32 : w[3:0];
      if (w[15:12] == 4'hF && w[7:0] == 8'h65) cnt = w[11:8] + 1;
      for (int k = 0; k < cnt; k++) begin
        a = 12'(ireg + 16'(k));
        if (!mem_set[a]) load_byte(a, 8'($urandom));
      end
    end
  endtask

  task automatic exec_word(input logic [15:0] w);
    begin
      fill_operands(w);
      load_byte(pc_q, w[15:8]);
      load_byte(pc_q + 12'd1, w[7:0]);
      send_item(random_item(OP_EXEC));
    end
  endtask

  function automatic logic [15:0] random_word();
    logic [15:0] w;
    logic [3:0] grp;
    logic [7:0] flist [10];
    logic [3:0] alu [10];
    begin
      flist = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h00};
      alu = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE, 4'h8};
      w = 16'($urandom);
      grp = w[15:12];
      case (grp)
        4'h0: case ($urandom_range(0, 3))
          0, 1: w = W_CLEAR;
          2: w = W_RETURN;
          default: ;
        endcase
        4'h3, 4'h4: if ($urandom_range(0, 1)) w[7:0] = vreg[w[11:8]];
        4'h5, 4'h9: if ($urandom_range(0, 5) != 0) w[3:0] = 4'h0;
        4'h8: w[3:0] = ($urandom_range(0, 9) == 9) ? 4'($urandom) : alu[$urandom_range(0, 8)];
        4'hE: case ($urandom_range(0, 4))
          0, 1: w[7:0] = 8'h9E;
          2, 3: w[7:0] = 8'hA1;
          default: ;
        endcase
        4'hF: if ($urandom_range(0, 9) != 0) begin
          w[7:0] = flist[$urandom_range(0, 8)];
        end
        default: ;
      endcase
      return w;
    end
  endfunction

  // return that would pop a never-pushed stack entry is swapped for a clear
  function automatic logic [15:0] legal_word(input logic [15:0] w);
    if (w == W_RETURN && !stack_set[sp_q - 4'd1]) return W_CLEAR;
    return w;
  endfunction

  task automatic program_step();
    logic [15:0] w;
    begin
      w = {mem_q[pc_q], mem_q[pc_q + 12'd1]};
      if (mem_set[pc_q] && mem_set[pc_q + 12'd1] && $urandom_range(0, 3) == 0 &&
          legal_word(w) == w) begin
        fill_operands(w);
        send_item(random_item(OP_EXEC));
      end else exec_word(legal_word(random_word()));
    end
  endtask

  task automatic wait_idle();
    begin
      push <= 1'b0;
      while (expected_q.size() != 0) @(posedge clk);
      repeat (120) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    begin
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
        REG_SHIFT: q_shift = val[0];
        REG_WRAP: q_wrap = val[0];
        REG_KEEP: q_keep = val[0];
        REG_VBLANK: q_vblank = val[0];
        REG_FONT: font_q = val[11:0];
        REG_BOOT: boot_q = val[11:0];
        default: ;
      endcase
    end
  endtask

  task automatic set_quirks(input bit sh, input bit wr, input bit kp, input bit vb,
                            input logic [11:0] font, input logic [11:0] boot);
    begin
      wait_idle();
      write_reg(REG_SHIFT, {31'd0, sh});
      write_reg(REG_WRAP, {31'd0, wr});
      write_reg(REG_KEEP, {31'd0, kp});
      write_reg(REG_VBLANK, {31'd0, vb});
      write_reg(REG_FONT, {20'd0, font});
      write_reg(REG_BOOT, {20'd0, boot});
    end
  endtask

  task automatic test_special_cases();
    request_t r;
    begin
      send_item(random_item(OP_TICK));       // timer already at zero
      exec_word(16'h60FF);
      exec_word(16'h7001);                   // register add wraps
      exec_word(16'h6101);
      exec_word(16'hF118);                   // length one raised to two
      exec_word(16'h6200);
      exec_word(16'hF218);                   // zero length still sounds
      exec_word(16'h0123);                   // illegal words
      exec_word(16'h812F);
      exec_word(16'hF0FF);
      exec_word(16'h6A3F);
      exec_word(16'hD1A0);                   // 16x16 at the bottom edge
      r = random_item(OP_PIXEL);
      r.address = 12'hFFF;                   // index beyond the screen
      send_item(r);
      send_item(random_item(3'd7));          // unknown operation
      exec_word(16'hF50A);
      r = random_item(OP_KEY);
      r.data_byte = 8'hFF;
      send_item(r);
      exec_word(W_CLEAR);
    end
  endtask

  task automatic test_random(input int count);
    int sel;
    request_t r;
    begin
      repeat (count) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) program_step();
        else if (sel < 76) send_item(random_item(OP_TICK));
        else if (sel < 82) send_item(random_item(OP_KEY));
        else if (sel < 92) begin
          r = random_item(OP_PIXEL);
          if ($urandom_range(0, 4) != 0) r.address[11] = 1'b0;
          send_item(r);
        end else if (sel < 96) send_item(random_item(OP_LOAD));
        else send_item(random_item(3'($urandom_range(5, 7))));
      end
    end
  endtask

  task automatic test_backpressure();
    begin
      quiet = 1'b1;
      hold_left = 400;
      test_random(20);
      quiet = 1'b0;
    end
  endtask

  // result checker and receiver stalls
  int pop_gap = 0;
  always @(posedge clk) begin
    result_t e;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, result.status);
          errors++;
        end
        if (result.program_counter !== e.program_counter) begin
          $display("%0t: pc exp %h got %h", $time, e.program_counter,
                   result.program_counter);
          errors++;
        end
        if (result.bad_instruction !== e.bad_instruction) begin
          $display("%0t: bad word exp %h got %h", $time, e.bad_instruction,
                   result.bad_instruction);
          errors++;
        end
        if (result.sound_duration !== e.sound_duration) begin
          $display("%0t: sound exp %0d got %0d", $time, e.sound_duration,
                   result.sound_duration);
          errors++;
        end
        if (result.pixel_value !== e.pixel_value) begin
          $display("%0t: pixel exp %b got %b", $time, e.pixel_value, result.pixel_value);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (!quiet && pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      pop_gap = $urandom_range(0, 6);
      pop <= 1'b0;
    end else pop <= 1'b1;
  end

  int stuck = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      vreg[i] = 8'd0;
      stack_q[i] = '0;
      stack_set[i] = 1'b0;
    end
    for (int i = 0; i < 4096; i++) begin
      mem_q[i] = 8'd0;
      mem_set[i] = 1'b0;
    end
    for (int i = 0; i < 2048; i++) screen[i] = 1'b0;
    ireg = '0;
    pc_q = BOOT_RESET;
    sp_q = '0;
    delay_q = '0;
    key_reg = '0;
    q_shift = 1'b0;
    q_wrap = 1'b0;
    q_keep = 1'b0;
    q_vblank = 1'b1;
    font_q = '0;
    boot_q = BOOT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    test_random(300);
    set_quirks(1'b1, 1'b1, 1'b1, 1'b0, 12'hFFF, 12'hFFF);
    test_random(300);
    test_backpressure();
    set_quirks(1'b0, 1'b0, 1'b0, 1'b1, 12'h000, 12'h000);
    test_random(300);
    set_quirks(1'($urandom), 1'b1, 1'($urandom), 1'($urandom), 12'($urandom),
               12'($urandom));
    test_random(200);
    quiet = 1'b1;
    test_random(200);

    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
